[sv/bqra_pkg.sv]
// ----------------------------------------------------------------------------
// bqra_pkg
// Word types, command and status groups and codes for the bounded queue
// with running average.
// ----------------------------------------------------------------------------
`default_nettype none

package bqra_pkg;

   localparam int ID_W     = 16;
   localparam int HEIGHT_W = 9;
   localparam int KIND_W   = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_AVERAGE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

   typedef struct packed {
      logic                mode;
      logic [ID_W-1:0]     player_id;
      logic [HEIGHT_W-1:0] height;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [HEIGHT_W-1:0] average;
      logic [ID_W-1:0]     removed_id;
      logic [HEIGHT_W-1:0] removed_height;
   } rsp_type;

   typedef struct packed {
      logic accept_insert;
      logic accept_remove;
      logic div_step;
      logic round_result;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

[sv/bounded_queue_running_average.sv]
// ----------------------------------------------------------------------------
// bounded_queue_running_average
// Bounded FIFO of identifier and height entries with a rounded running
// mean of the stored heights reported after every insert.
// ----------------------------------------------------------------------------
// Insert: the result is set by the one-bit-a-cycle divider over the SUM_W-bit
//   height sum, then rounded into the result register.
// Remove: the result goes straight into the result register.
// One word in flight; the next is taken the cycle after the result is
//   loaded into the output register, even while that result is stalled.
// Synchronous reset empties the FIFO and clears the sum; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_queue_running_average
   import bqra_pkg::*;
#(
   parameter int DEPTH = 5
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   bqra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bqra_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while one is in flight");

   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> req_stall)
      else $error("input taken during division");

   a_insert_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_AVERAGE)
         |-> (rsp_data.removed_id == '0 && rsp_data.removed_height == '0))
      else $error("average result carries removed entry fields");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[sv/bqra_ctrl.sv]
// ----------------------------------------------------------------------------
// bqra_ctrl
// Sequencer: takes one word at a time, runs the divider on inserts and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bqra_ctrl
   import bqra_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_mode,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_RND  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_REMOVE) begin
                  cmd.accept_remove = 1'b1;
                  state_in          = S_OUT;
               end else begin
                  cmd.accept_insert = 1'b1;
                  state_in          = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            cmd.round_result = 1'b1;
            state_in         = S_OUT;
         end
         S_OUT: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[sv/bqra_dp.sv]
// ----------------------------------------------------------------------------
// bqra_dp
// Datapath: circular entry store, running height sum, bit-serial restoring
// divider with round-half-even, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bqra_dp
   import bqra_pkg::*;
#(
   parameter int DEPTH = 5
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output rsp_type      rsp_data
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W  = CNT_W + 1;
   localparam int SUM_W  = HEIGHT_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);

   logic [ID_W-1:0]     ids_ff     [DEPTH];
   logic [HEIGHT_W-1:0] heights_ff [DEPTH];

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;

   rsp_type res_ff;
   rsp_type out_ff;

   logic                full, empty;
   logic [IDX_W-1:0]    head_next;
   logic [PTR_W-1:0]    tail_raw, tail_wrap;
   logic [IDX_W-1:0]    tail_idx;
   logic [ID_W-1:0]     head_id;
   logic [HEIGHT_W-1:0] head_h;

   logic [CNT_W:0]      trial;
   logic                trial_ge;
   logic [CNT_W:0]      trial_diff;
   logic [CNT_W:0]      twice_rem;
   logic [CNT_W:0]      count_ext;
   logic                round_up;
   logic [HEIGHT_W-1:0] average;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   // a full insert lands on the head slot, which is where the tail wraps to
   assign tail_raw  = PTR_W'(head_ff) + PTR_W'(count_ff);
   assign tail_wrap = (tail_raw >= PTR_W'(DEPTH)) ? tail_raw - PTR_W'(DEPTH) : tail_raw;
   assign tail_idx  = tail_wrap[IDX_W-1:0];

   assign head_id = ids_ff[head_ff];
   assign head_h  = heights_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.accept_insert) begin
         if (full) begin
            head_in = head_next;
            sum_in  = sum_ff - SUM_W'(head_h) + SUM_W'(req_data.height);
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(req_data.height);
         end
      end else if (cmd.accept_remove && !empty) begin
         head_in  = head_next;
         count_in = count_ff - CNT_W'(1);
         sum_in   = sum_ff - SUM_W'(head_h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_insert) begin
         ids_ff[tail_idx]     <= req_data.player_id;
         heights_ff[tail_idx] <= req_data.height;
      end
   end

   // restoring division of the new sum by the new count, one bit a cycle
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign count_ext  = {1'b0, count_ff};
   assign trial_ge   = (trial >= count_ext);
   assign trial_diff = trial - count_ext;

   always_ff @(posedge clock) begin
      if (cmd.accept_insert) begin
         quo_ff  <= sum_in;
         rem_ff  <= '0;
         step_ff <= STEP_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], trial_ge};
         rem_ff  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign status.div_last = (step_ff == '0);

   // round to nearest, ties to even
   assign twice_rem = {rem_ff, 1'b0};
   assign round_up  = (twice_rem > count_ext) || ((twice_rem == count_ext) && quo_ff[0]);
   assign average   = quo_ff[HEIGHT_W-1:0] + HEIGHT_W'(round_up);

   always_ff @(posedge clock) begin
      if (cmd.accept_remove) begin
         res_ff.average <= '0;
         if (empty) begin
            res_ff.result_kind    <= KIND_EMPTY;
            res_ff.removed_id     <= '0;
            res_ff.removed_height <= '0;
         end else begin
            res_ff.result_kind    <= KIND_REMOVED;
            res_ff.removed_id     <= head_id;
            res_ff.removed_height <= head_h;
         end
      end else if (cmd.round_result) begin
         res_ff.result_kind    <= KIND_AVERAGE;
         res_ff.average        <= average;
         res_ff.removed_id     <= '0;
         res_ff.removed_height <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire
